// ===== rtl/core/adaptive_level_governor_macros.svh =====
// Assertion macros shared by the level governor RTL.
`ifndef ADAPTIVE_LEVEL_GOVERNOR_MACROS_SVH
`define ADAPTIVE_LEVEL_GOVERNOR_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ALG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ALG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/alg_pkg.sv =====
// Types, constants and helpers of the adaptive level governor.
`timescale 1ns / 1ps
`default_nettype none

package alg_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int LEVELS_DEF     = 8;

    localparam int FPS_W   = 10;
    localparam int TIME_W  = 32;
    localparam int ELAP_W  = 16;
    localparam int LVL_W   = 3;
    localparam int DIST_W  = 7;
    localparam int THR_W   = 10;
    localparam int WIN_W   = 16;
    localparam int TBL_W   = 56;
    localparam int APB_DW  = 64;
    localparam int APB_AW  = 6;

    localparam logic [THR_W-1:0] HIGH_THR_RST = THR_W'(50);
    localparam logic [THR_W-1:0] LOW_THR_RST  = THR_W'(30);
    localparam logic [WIN_W-1:0] UP_WIN_RST   = WIN_W'(3000);
    localparam logic [WIN_W-1:0] DN_WIN_RST   = WIN_W'(1000);
    localparam logic [WIN_W-1:0] COOL_RST     = WIN_W'(1000);

    typedef enum logic [2:0] {
        REG_HIGH_THR = 3'd0,
        REG_LOW_THR  = 3'd1,
        REG_UP_WIN   = 3'd2,
        REG_DN_WIN   = 3'd3,
        REG_COOL     = 3'd4,
        REG_DIST_TBL = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_EXP_RD,
        S_EXP_CHK,
        S_DEC,
        S_CMP_UP,
        S_CMP_DN,
        S_DONE
    } t_state;

    function automatic logic [DIST_W-1:0] table_entry(input logic [TBL_W-1:0] tbl,
                                                      input logic [LVL_W-1:0] lvl);
        return tbl[lvl*DIST_W +: DIST_W];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/alg_if.sv =====
// Stream interfaces for governor samples and governor results.
`timescale 1ns / 1ps
`default_nettype none

interface alg_in_if;
    logic                         valid;
    logic                         ready;
    logic [alg_pkg::FPS_W-1:0]    fps;
    logic [alg_pkg::TIME_W-1:0]   time_ms;
    logic [alg_pkg::ELAP_W-1:0]   elapsed_ms;

    modport source (output valid, output fps, output time_ms, output elapsed_ms,
                    input ready);
    modport sink   (input valid, input fps, input time_ms, input elapsed_ms,
                    output ready);
endinterface

interface alg_out_if;
    logic                         valid;
    logic                         ready;
    logic [alg_pkg::LVL_W-1:0]    level;
    logic [alg_pkg::DIST_W-1:0]   render_distance;
    logic                         decision_made;
    logic                         level_changed;

    modport source (output valid, output level, output render_distance,
                    output decision_made, output level_changed, input ready);
    modport sink   (input valid, input level, input render_distance,
                    input decision_made, input level_changed, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/adaptive_level_governor.sv =====
// Adaptive level governor: two-window fps averaging with cooldown and level stepping.
`timescale 1ns / 1ps
`default_nettype none

// One sample per transfer on i_in, one result per sample on o_out. Samples go into a
// ring memory shared by a long upscale window and a short downscale window. Every
// ring access goes through a single read port with registered data, so each expired
// sample costs a read and a check state. A sample passes S_FILL, the expiry states,
// S_DEC, both compare states when the cooldown runs out (the two threshold compares
// share one multiplier) and S_DONE before the next transfer. Averages are never
// divided out: the thresholds are tested as sum against threshold times count. The
// result register holds a finished result while the next sample is taken. Registers
// sit on an APB port, 8 bytes apart; ring entries need no clearing after reset.
module adaptive_level_governor #(
    parameter int RING_DEPTH = alg_pkg::RING_DEPTH_DEF,
    parameter int LEVELS     = alg_pkg::LEVELS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    alg_in_if.sink                       i_in,
    alg_out_if.source                    o_out,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [alg_pkg::APB_AW-1:0]    paddr,
    input  wire [alg_pkg::APB_DW-1:0]    pwdata,
    output logic [alg_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

`include "adaptive_level_governor_macros.svh"

    localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = CNT_W + alg_pkg::FPS_W;
    localparam int MA_W   = alg_pkg::THR_W + 1;
    localparam int PROD_W = MA_W + CNT_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [alg_pkg::LVL_W-1:0] LVL_TOP = alg_pkg::LVL_W'(LEVELS - 1);

    // configuration
    logic [alg_pkg::THR_W-1:0]  r_high_thr, r_low_thr;
    logic [alg_pkg::WIN_W-1:0]  r_up_win, r_dn_win, r_cool_ms;
    logic [alg_pkg::TBL_W-1:0]  r_tbl;

    // sequencer and window state
    alg_pkg::t_state            r_state, n_state;
    logic                       r_sel, n_sel;
    logic [IDX_W-1:0]           r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]           r_up_old, n_up_old, r_dn_old, n_dn_old;
    logic [CNT_W-1:0]           r_up_cnt, n_up_cnt, r_dn_cnt, n_dn_cnt;
    logic [SUM_W-1:0]           r_up_sum, n_up_sum, r_dn_sum, n_dn_sum;
    logic [alg_pkg::LVL_W-1:0]  r_level, n_level;
    logic [alg_pkg::WIN_W-1:0]  r_cool, n_cool;
    logic                       r_go_up, n_go_up;
    logic                       r_decided, n_decided;
    logic                       r_changed, n_changed;
    logic                       r_out_valid, n_out_valid;

    // sample payload and datapath registers
    logic [alg_pkg::FPS_W-1:0]  r_fps;
    logic [alg_pkg::TIME_W-1:0] r_now;
    logic [alg_pkg::ELAP_W-1:0] r_elap;
    logic [PROD_W-1:0]          r_prod;
    logic [alg_pkg::TIME_W-1:0] r_rd_time;
    logic [alg_pkg::FPS_W-1:0]  r_rd_rate;
    logic [alg_pkg::LVL_W-1:0]  r_out_level;
    logic [alg_pkg::DIST_W-1:0] r_out_dist;
    logic                       r_out_dec, r_out_chg;

    // ring memory
    logic [alg_pkg::TIME_W-1:0] r_mem_time [RING_DEPTH];
    logic [alg_pkg::FPS_W-1:0]  r_mem_rate [RING_DEPTH];

    logic [IDX_W-1:0]           rd_addr;
    logic                       in_xfer, out_load, mem_we, prod_en;
    logic [MA_W-1:0]            mul_a;
    logic [CNT_W-1:0]           mul_b;
    logic [PROD_W-1:0]          mul_p;
    logic [alg_pkg::TIME_W-1:0] age;
    logic [alg_pkg::WIN_W-1:0]  win_eff;
    logic [CNT_W-1:0]           cur_cnt;
    logic                       expire;
    logic                       go_dn;
    logic                       cfg_wr;
    alg_pkg::t_reg_idx          cfg_idx;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
    endfunction

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = alg_pkg::t_reg_idx'(paddr[alg_pkg::APB_AW-1:3]);

    always_comb begin
        unique case (cfg_idx)
            alg_pkg::REG_HIGH_THR: prdata = alg_pkg::APB_DW'(r_high_thr);
            alg_pkg::REG_LOW_THR:  prdata = alg_pkg::APB_DW'(r_low_thr);
            alg_pkg::REG_UP_WIN:   prdata = alg_pkg::APB_DW'(r_up_win);
            alg_pkg::REG_DN_WIN:   prdata = alg_pkg::APB_DW'(r_dn_win);
            alg_pkg::REG_COOL:     prdata = alg_pkg::APB_DW'(r_cool_ms);
            alg_pkg::REG_DIST_TBL: prdata = alg_pkg::APB_DW'(r_tbl);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr <= alg_pkg::HIGH_THR_RST;
            r_low_thr  <= alg_pkg::LOW_THR_RST;
            r_up_win   <= alg_pkg::UP_WIN_RST;
            r_dn_win   <= alg_pkg::DN_WIN_RST;
            r_cool_ms  <= alg_pkg::COOL_RST;
            r_tbl      <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                alg_pkg::REG_HIGH_THR: r_high_thr <= pwdata[alg_pkg::THR_W-1:0];
                alg_pkg::REG_LOW_THR:  r_low_thr  <= pwdata[alg_pkg::THR_W-1:0];
                alg_pkg::REG_UP_WIN:   r_up_win   <= pwdata[alg_pkg::WIN_W-1:0];
                alg_pkg::REG_DN_WIN:   r_dn_win   <= pwdata[alg_pkg::WIN_W-1:0];
                alg_pkg::REG_COOL:     r_cool_ms  <= pwdata[alg_pkg::WIN_W-1:0];
                alg_pkg::REG_DIST_TBL: r_tbl      <= pwdata[alg_pkg::TBL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshakes ----------------
    assign i_in.ready            = (r_state == alg_pkg::S_IDLE);
    assign in_xfer               = i_in.valid & i_in.ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.level           = r_out_level;
    assign o_out.render_distance = r_out_dist;
    assign o_out.decision_made   = r_out_dec;
    assign o_out.level_changed   = r_out_chg;

    // ---------------- shared multiplier ----------------
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // ---------------- expiry compare ----------------
    assign cur_cnt = r_sel ? r_dn_cnt : r_up_cnt;
    assign win_eff = ((r_sel ? r_dn_win : r_up_win) == '0) ? alg_pkg::WIN_W'(1)
                   : (r_sel ? r_dn_win : r_up_win);
    assign age     = r_now - r_rd_time;
    assign expire  = (cur_cnt != '0) && (age >= alg_pkg::TIME_W'(win_eff));
    assign go_dn   = PROD_W'(r_dn_sum) < r_prod;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_wr_idx    = r_wr_idx;
        n_up_old    = r_up_old;
        n_dn_old    = r_dn_old;
        n_up_cnt    = r_up_cnt;
        n_dn_cnt    = r_dn_cnt;
        n_up_sum    = r_up_sum;
        n_dn_sum    = r_dn_sum;
        n_level     = r_level;
        n_cool      = r_cool;
        n_go_up     = r_go_up;
        n_decided   = r_decided;
        n_changed   = r_changed;
        rd_addr     = r_wr_idx;
        mem_we      = 1'b0;
        prod_en     = 1'b0;
        out_load    = 1'b0;
        mul_a       = MA_W'(r_high_thr) + MA_W'(1);
        mul_b       = r_up_cnt;

        unique case (r_state)
            alg_pkg::S_IDLE: begin
                // fetch the slot about to be overwritten
                rd_addr = r_wr_idx;
                if (in_xfer) begin
                    n_state = alg_pkg::S_FILL;
                end
            end
            alg_pkg::S_FILL: begin
                mem_we = 1'b1;
                // a full window starts at the write slot: swap its sample out
                if (r_up_cnt == CNT_FULL) begin
                    n_up_sum = r_up_sum - SUM_W'(r_rd_rate) + SUM_W'(r_fps);
                    n_up_old = ring_next(r_up_old);
                end else begin
                    n_up_sum = r_up_sum + SUM_W'(r_fps);
                    n_up_cnt = r_up_cnt + CNT_W'(1);
                    if (r_up_cnt == '0) begin
                        n_up_old = r_wr_idx;
                    end
                end
                if (r_dn_cnt == CNT_FULL) begin
                    n_dn_sum = r_dn_sum - SUM_W'(r_rd_rate) + SUM_W'(r_fps);
                    n_dn_old = ring_next(r_dn_old);
                end else begin
                    n_dn_sum = r_dn_sum + SUM_W'(r_fps);
                    n_dn_cnt = r_dn_cnt + CNT_W'(1);
                    if (r_dn_cnt == '0) begin
                        n_dn_old = r_wr_idx;
                    end
                end
                n_wr_idx = ring_next(r_wr_idx);
                n_sel    = 1'b0;
                n_state  = alg_pkg::S_EXP_RD;
            end
            alg_pkg::S_EXP_RD: begin
                rd_addr = r_sel ? r_dn_old : r_up_old;
                n_state = alg_pkg::S_EXP_CHK;
            end
            alg_pkg::S_EXP_CHK: begin
                priority if (expire) begin
                    if (r_sel) begin
                        n_dn_sum = r_dn_sum - SUM_W'(r_rd_rate);
                        n_dn_cnt = r_dn_cnt - CNT_W'(1);
                        n_dn_old = ring_next(r_dn_old);
                    end else begin
                        n_up_sum = r_up_sum - SUM_W'(r_rd_rate);
                        n_up_cnt = r_up_cnt - CNT_W'(1);
                        n_up_old = ring_next(r_up_old);
                    end
                    n_state = alg_pkg::S_EXP_RD;
                end else if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = alg_pkg::S_EXP_RD;
                end else begin
                    n_state = alg_pkg::S_DEC;
                end
            end
            alg_pkg::S_DEC: begin
                // up test: floor(sum / count) > high  <=>  sum >= (high + 1) * count
                mul_a   = MA_W'(r_high_thr) + MA_W'(1);
                mul_b   = r_up_cnt;
                prod_en = 1'b1;
                if (r_elap >= r_cool) begin
                    n_cool  = r_cool_ms;
                    n_state = alg_pkg::S_CMP_UP;
                end else begin
                    n_cool    = r_cool - r_elap;
                    n_decided = 1'b0;
                    n_changed = 1'b0;
                    n_state   = alg_pkg::S_DONE;
                end
            end
            alg_pkg::S_CMP_UP: begin
                // down test: floor(sum / count) < low  <=>  sum < low * count
                n_go_up = PROD_W'(r_up_sum) >= r_prod;
                mul_a   = MA_W'(r_low_thr);
                mul_b   = r_dn_cnt;
                prod_en = 1'b1;
                n_state = alg_pkg::S_CMP_DN;
            end
            alg_pkg::S_CMP_DN: begin
                n_decided = 1'b1;
                n_changed = 1'b0;
                priority if (r_go_up && !go_dn) begin
                    if (r_level != LVL_TOP) begin
                        n_level   = r_level + alg_pkg::LVL_W'(1);
                        n_changed = 1'b1;
                    end
                end else if (go_dn && !r_go_up) begin
                    if (r_level != '0) begin
                        n_level   = r_level - alg_pkg::LVL_W'(1);
                        n_changed = 1'b1;
                    end
                end else begin
                    n_level = r_level;
                end
                n_state = alg_pkg::S_DONE;
            end
            alg_pkg::S_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = alg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = alg_pkg::S_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && !o_out.ready) || out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alg_pkg::S_IDLE;
            r_sel       <= 1'b0;
            r_wr_idx    <= '0;
            r_up_old    <= '0;
            r_dn_old    <= '0;
            r_up_cnt    <= '0;
            r_dn_cnt    <= '0;
            r_up_sum    <= '0;
            r_dn_sum    <= '0;
            r_level     <= LVL_TOP;
            r_cool      <= alg_pkg::COOL_RST;
            r_go_up     <= 1'b0;
            r_decided   <= 1'b0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_wr_idx    <= n_wr_idx;
            r_up_old    <= n_up_old;
            r_dn_old    <= n_dn_old;
            r_up_cnt    <= n_up_cnt;
            r_dn_cnt    <= n_dn_cnt;
            r_up_sum    <= n_up_sum;
            r_dn_sum    <= n_dn_sum;
            r_level     <= n_level;
            r_cool      <= n_cool;
            r_go_up     <= n_go_up;
            r_decided   <= n_decided;
            r_changed   <= n_changed;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and ring memory
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_fps  <= i_in.fps;
            r_now  <= i_in.time_ms;
            r_elap <= i_in.elapsed_ms;
        end
        if (prod_en) begin
            r_prod <= mul_p;
        end
        if (mem_we) begin
            r_mem_time[r_wr_idx] <= r_now;
            r_mem_rate[r_wr_idx] <= r_fps;
        end
        r_rd_time <= r_mem_time[rd_addr];
        r_rd_rate <= r_mem_rate[rd_addr];
        if (out_load) begin
            r_out_level <= r_level;
            r_out_dist  <= alg_pkg::table_entry(r_tbl, r_level);
            r_out_dec   <= r_decided;
            r_out_chg   <= r_changed;
        end
    end

    // ---------------- assertions ----------------
    `ALG_ASSERT_NOW(a_cnt_bound, 1'b1, (r_up_cnt <= CNT_FULL) && (r_dn_cnt <= CNT_FULL), "window count above ring depth")
    `ALG_ASSERT_NOW(a_newest_kept, r_state == alg_pkg::S_DEC, (r_up_cnt != '0) && (r_dn_cnt != '0), "window emptied by expiry")
    `ALG_ASSERT_NOW(a_level_bound, 1'b1, r_level <= LVL_TOP, "level above top")
    `ALG_ASSERT_NOW(a_chg_needs_dec, r_out_valid, r_out_dec || !r_out_chg, "level moved without a decision")
    `ALG_ASSERT_NEXT(a_fill_once, r_state == alg_pkg::S_FILL, r_state == alg_pkg::S_EXP_RD && !r_sel, "fill not followed by up-window expiry")

endmodule

`default_nettype wire
